[hw/rtl/adts_frame_sync_and_duration_core_defines.svh]
// Assertion macros shared by the frame sync checker.
// Uses clock and reset as named on the core's ports.
`ifndef ADTS_FRAME_SYNC_AND_DURATION_CORE_DEFINES_SVH
`define ADTS_FRAME_SYNC_AND_DURATION_CORE_DEFINES_SVH

// same-cycle implication
`define AFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("afs same-cycle check failed");

// next-cycle implication
`define AFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("afs next-cycle check failed");

`endif

[hw/rtl/afs_pkg.sv]
// Types, codes and the sample rate table of the ADTS frame sync core.
// No dependencies.
package afs_pkg;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic RK_VERDICT = 1'b0;
   localparam logic RK_SUMMARY = 1'b1;

   localparam logic [1:0] CLS_DISCARD = 2'd0;
   localparam logic [1:0] CLS_START   = 2'd1;
   localparam logic [1:0] CLS_BODY    = 2'd2;
   localparam logic [1:0] CLS_END     = 2'd3;

   localparam logic [7:0] SYNC_BYTE  = 8'hFF;
   localparam logic [7:0] SYNC_MASK  = 8'hF6;
   localparam logic [7:0] SYNC_MATCH = 8'hF0;
   localparam int HDR_BYTES = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int RATE_W = 17;
   localparam int DUR_W  = 40;
   localparam int FC_W   = 32;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } afs_req_type;

   typedef struct packed {
      logic              result_kind;
      logic [7:0]        out_byte;
      logic [1:0]        byte_class;
      logic              last;
      logic [FC_W-1:0]   frame_count;
      logic [RATE_W-1:0] sample_rate_hz;
      logic [DUR_W-1:0]  duration_ms;
      logic              duration_valid;
      logic              truncated;
   } afs_rsp_type;

   typedef struct packed {
      logic        valid;
      afs_req_type item;
   } afs_head_type;

   function automatic logic [RATE_W-1:0] afs_rate_hz(input logic [3:0] idx);
      logic [RATE_W-1:0] r;
      case (idx)
         4'd0:    r = 17'd96000;
         4'd1:    r = 17'd88200;
         4'd2:    r = 17'd64000;
         4'd3:    r = 17'd48000;
         4'd4:    r = 17'd44100;
         4'd5:    r = 17'd32000;
         4'd6:    r = 17'd24000;
         4'd7:    r = 17'd22050;
         4'd8:    r = 17'd16000;
         4'd9:    r = 17'd12000;
         4'd10:   r = 17'd11025;
         4'd11:   r = 17'd8000;
         4'd12:   r = 17'd7350;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/afs_queue.sv]
// Input side: accepts request transfers into a short queue.
// Depends on afs_pkg.
module afs_queue
   import afs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  afs_req_type  req_payload,
   output afs_head_type head,
   input  logic         head_pop
);

   afs_req_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign req_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

[hw/rtl/afs_div.sv]
// Restoring divider, one quotient bit per cycle, for the duration.
// Depends on afs_pkg.
module afs_div
   import afs_pkg::*;
#(
   parameter int DW = 52
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic              busy,
   output logic [DW-1:0]     quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]     dvd_ff, dvd_in;
   logic [RATE_W-1:0] dsr_ff, dsr_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [RATE_W:0]   rem_sh;
   logic [RATE_W:0]   rem_sub;
   logic              fits;

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DW-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      fits    = (rem_sh >= {1'b0, dsr_ff});
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DW-2:0], fits};
         rem_in = fits ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

endmodule

[hw/rtl/afs_engine.sv]
// Back end: lookahead window, byte verdicts, drain and summary sequencing.
// Depends on afs_pkg and afs_div.
module afs_engine
   import afs_pkg::*;
#(
   parameter int WINDOW_BYTES = 6,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  afs_head_type head,
   output logic         head_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output afs_rsp_type  rsp_payload
);

   localparam int W      = WINDOW_BYTES;
   localparam int FILL_W = $clog2(W + 1);
   localparam int IDX_W  = $clog2(W);
   localparam int DW     = COUNT_WIDTH + 20;
   localparam int QX     = (DW > DUR_W) ? DW : DUR_W;
   localparam int FX     = (COUNT_WIDTH > FC_W) ? COUNT_WIDTH : FC_W;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_SUM   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [7:0]             win_ff [W];
   logic [7:0]             win_in [W];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic                   in_frame_ff, in_frame_in;
   logic [12:0]            left_ff, left_in;
   logic [COUNT_WIDTH-1:0] frames_ff, frames_in;
   logic [3:0]             ridx_ff, ridx_in;
   logic                   rcap_ff, rcap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   afs_rsp_type            rsp_ff, rsp_in;

   logic [7:0]             jw [W];
   logic                   ge6;
   logic [12:0]            hlen;
   logic                   hdr;
   logic [12:0]            left_dec;
   logic [1:0]             j_cls;
   logic                   j_in_frame;
   logic [12:0]            j_left;
   logic [COUNT_WIDTH-1:0] j_frames;
   logic [3:0]             j_ridx;
   logic                   j_rcap;
   logic                   out_free;

   logic [RATE_W-1:0]      rate;
   logic                   dv;
   logic [DW-1:0]          fext;
   logic [DW-1:0]          dividend;
   logic                   div_start;
   logic                   div_busy;
   logic [DW-1:0]          quot;
   logic [QX-1:0]          quot_ext;
   logic [FX-1:0]          frames_ext;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // judge the oldest byte of the working window
   always_comb begin
      for (int i = 0; i < W; i++) begin
         jw[i] = win_ff[i];
      end
      if (state_ff == ST_RUN) begin
         jw[W-1] = head.item.byte_value;
      end
      ge6  = (state_ff == ST_RUN) || (fill_ff >= FILL_W'(HDR_BYTES));
      hlen = {jw[3][1:0], jw[4], jw[5][7:5]};
      hdr  = ge6 && (jw[0] == SYNC_BYTE) && ((jw[1] & SYNC_MASK) == SYNC_MATCH)
             && (hlen != '0);
      left_dec   = left_ff - 1'b1;
      j_cls      = CLS_DISCARD;
      j_in_frame = in_frame_ff;
      j_left     = left_ff;
      j_frames   = frames_ff;
      j_ridx     = ridx_ff;
      j_rcap     = rcap_ff;
      if (in_frame_ff) begin
         j_left = left_dec;
         j_cls  = (left_dec == '0) ? CLS_END : CLS_BODY;
      end else if (hdr) begin
         j_cls = CLS_START;
         if (!rcap_ff) begin
            j_ridx = jw[2][5:2];
         end
         j_in_frame = 1'b1;
         j_left     = hlen - 1'b1;
      end
      if ((in_frame_ff && left_dec == '0) || (!in_frame_ff && hdr && hlen == 13'd1)) begin
         if (frames_ff != '1) begin
            j_frames = frames_ff + 1'b1;
         end
         j_rcap     = 1'b1;
         j_in_frame = 1'b0;
         j_left     = '0;
      end
   end

   // summary terms
   always_comb begin
      rate     = rcap_ff ? afs_rate_hz(ridx_ff) : '0;
      dv       = (frames_ff != '0) && (rate != '0);
      fext     = DW'(frames_ff);
      dividend = ((fext << 7) - (fext << 2) + fext) << 13;
      quot_ext = QX'(quot);
      frames_ext = FX'(frames_ff);
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      in_frame_in  = in_frame_ff;
      left_in      = left_ff;
      frames_in    = frames_ff;
      ridx_in      = ridx_ff;
      rcap_in      = rcap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      head_pop     = 1'b0;
      div_start    = 1'b0;
      for (int i = 0; i < W; i++) begin
         win_in[i] = win_ff[i];
      end
      unique case (state_ff)
         ST_RUN: begin
            if (head.valid) begin
               if (head.item.kind == KIND_FLUSH) begin
                  head_pop = 1'b1;
                  state_in = ST_DRAIN;
               end else if (fill_ff != FILL_W'(W - 1)) begin
                  head_pop = 1'b1;
                  win_in[fill_ff[IDX_W-1:0]] = head.item.byte_value;
                  fill_in = fill_ff + 1'b1;
               end else if (out_free) begin
                  head_pop    = 1'b1;
                  in_frame_in = j_in_frame;
                  left_in     = j_left;
                  frames_in   = j_frames;
                  ridx_in     = j_ridx;
                  rcap_in     = j_rcap;
                  for (int i = 0; i < W - 1; i++) begin
                     win_in[i] = jw[i+1];
                  end
                  win_in[W-1]       = '0;
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.result_kind = RK_VERDICT;
                  rsp_in.out_byte   = jw[0];
                  rsp_in.byte_class = j_cls;
                  rsp_in.last       = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (fill_ff == '0) begin
               if (dv) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_SUM;
               end
            end else if (out_free) begin
               in_frame_in = j_in_frame;
               left_in     = j_left;
               frames_in   = j_frames;
               ridx_in     = j_ridx;
               rcap_in     = j_rcap;
               fill_in     = fill_ff - 1'b1;
               for (int i = 0; i < W - 1; i++) begin
                  win_in[i] = jw[i+1];
               end
               win_in[W-1]        = '0;
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.result_kind = RK_VERDICT;
               rsp_in.out_byte    = jw[0];
               rsp_in.byte_class  = j_cls;
               rsp_in.last        = 1'b0;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.result_kind = RK_SUMMARY;
               rsp_in.last        = 1'b1;
               rsp_in.frame_count = (frames_ext > FX'(32'hFFFF_FFFF)) ? '1
                                    : frames_ext[FC_W-1:0];
               rsp_in.sample_rate_hz = rate;
               rsp_in.duration_valid = dv;
               rsp_in.truncated      = in_frame_ff;
               if (dv) begin
                  rsp_in.duration_ms = (quot_ext > QX'(40'hFF_FFFF_FFFF)) ? '1
                                       : quot_ext[DUR_W-1:0];
               end
               fill_in     = '0;
               in_frame_in = 1'b0;
               left_in     = '0;
               frames_in   = '0;
               ridx_in     = '0;
               rcap_in     = 1'b0;
               state_in    = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         fill_ff      <= '0;
         in_frame_ff  <= 1'b0;
         left_ff      <= '0;
         frames_ff    <= '0;
         ridx_ff      <= '0;
         rcap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         in_frame_ff  <= in_frame_in;
         left_ff      <= left_in;
         frames_ff    <= frames_in;
         ridx_ff      <= ridx_in;
         rcap_ff      <= rcap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int i = 0; i < W; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   afs_div #(
      .DW (DW)
   ) u_afs_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (rate),
      .busy     (div_busy),
      .quotient (quot)
   );

endmodule

[hw/rtl/adts_frame_sync_and_duration_core.sv]
// Verdicts: a byte is held in the queue register; the verdict it causes is registered.
// Throughput: one stream byte per cycle from the single judge step, unless stalled.
// End of stream: drain verdicts for the up to WINDOW_BYTES-1 window bytes, a setup step,
// the divide when a duration is valid, then the summary.
// Reset: synchronous, active high; clears queue, window level, frame state, rsp_valid.
module adts_frame_sync_and_duration_core
   import afs_pkg::*;
#(
   parameter int WINDOW_BYTES = 6,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  afs_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output afs_rsp_type rsp_payload
);

   afs_head_type head;
   logic         head_pop;

   afs_queue u_afs_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .head        (head),
      .head_pop    (head_pop)
   );

   afs_engine #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_afs_engine (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_pop    (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/afs_checker.sv]
// Port-level checks on the ADTS frame sync core, bound to the top level.
// Depends on afs_pkg and adts_frame_sync_and_duration_core_defines.svh.
`include "adts_frame_sync_and_duration_core_defines.svh"

module afs_checker
   import afs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input afs_req_type req_payload,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input afs_rsp_type rsp_payload
);

   logic verdict;
   logic summary;
   logic verdict_clean;
   logic valid_terms;

   assign verdict = rsp_valid && (rsp_payload.result_kind == RK_VERDICT);
   assign summary = rsp_valid && (rsp_payload.result_kind == RK_SUMMARY);
   assign verdict_clean = (rsp_payload.frame_count == '0) && (rsp_payload.duration_ms == '0)
                          && !rsp_payload.duration_valid && !rsp_payload.truncated;
   assign valid_terms = (rsp_payload.frame_count != '0)
                        && (rsp_payload.sample_rate_hz != '0);

   `AFS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_payload))
   `AFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `AFS_ASSERT_NOW(a_summary_last, summary, rsp_payload.last)
   `AFS_ASSERT_NOW(a_valid_terms, summary && rsp_payload.duration_valid, valid_terms)
   `AFS_ASSERT_NOW(a_verdict_clean, verdict, verdict_clean)

endmodule

bind adts_frame_sync_and_duration_core afs_checker u_afs_checker (.*);
